// ===== rtl/core/jpid_pkg.sv =====
`timescale 1ns / 1ps

package jpid_pkg;

   localparam int JOINTS  = 3;
   localparam int STAGES  = 6;

   // field and register widths
   localparam int ANGLE_W  = 16;
   localparam int GAIN_W   = 16;
   localparam int WINDOW_W = 15;
   localparam int LIMIT_W  = 15;
   localparam int TORQUE_W = 16;

   // datapath widths
   localparam int ERR_W    = ANGLE_W + 1;
   localparam int VEL_W    = 27;
   localparam int SUM_W    = VEL_W + 2;
   localparam int INT_W    = 32;
   localparam int P_W      = GAIN_W + 1 + ERR_W;
   localparam int D_W      = GAIN_W + 1 + VEL_W;
   localparam int I_W      = GAIN_W + 1 + INT_W;
   localparam int PD_W     = D_W + 1;
   localparam int NUM_W    = 56;
   localparam int TQ_SH    = 12;
   localparam int SCALED_W = NUM_W - TQ_SH;
   localparam int SPAN_W   = 23;
   localparam int QUOT_W   = 17;

   localparam int TICKS_PER_SEC = 1000;

   // divide by three: multiply by the rounded-up reciprocal, exact below 2^29
   localparam int RECIP3_W  = 29;
   localparam int RECIP3_SH = 30;
   localparam logic [RECIP3_W-1:0] RECIP3 = 29'd357913942;

   // torque divisor 512000 = 2^12 * 125; the odd part goes by reciprocal
   localparam int RECIP125_W  = 24;
   localparam int RECIP125_SH = 30;
   localparam logic [RECIP125_W-1:0] RECIP125 = 24'd8589935;
   localparam int TQ_DIV_ODD = 125;
   localparam int TQ_BIAS    = 32768;
   localparam int TQ_SPAN    = TQ_BIAS * TQ_DIV_ODD;

   localparam logic [GAIN_W-1:0]   RST_GAIN_P = 16'd15360;
   localparam logic [GAIN_W-1:0]   RST_GAIN_D = 16'd256;
   localparam logic [GAIN_W-1:0]   RST_GAIN_I = 16'd77;
   localparam logic [WINDOW_W-1:0] RST_WINDOW = 15'd819;
   localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 15'd20480;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_GAIN_P = 3'd0,
      REG_GAIN_D = 3'd1,
      REG_GAIN_I = 3'd2,
      REG_WINDOW = 3'd3,
      REG_LIMIT  = 3'd4
   } jpid_reg_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_d;
      logic [GAIN_W-1:0]   gain_i;
      logic [WINDOW_W-1:0] window;
      logic [LIMIT_W-1:0]  limit;
   } jpid_cfg_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [1:0]        take;
   } jpid_ctl_type;

endpackage

// ===== rtl/core/jpid_req_if.sv =====
`timescale 1ns / 1ps

interface jpid_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] measured_angle_a;
   logic signed [15:0] measured_angle_b;
   logic signed [15:0] measured_angle_c;
   logic signed [15:0] target_angle_a;
   logic signed [15:0] target_angle_b;
   logic signed [15:0] target_angle_c;

   modport source (
      output valid, measured_angle_a, measured_angle_b, measured_angle_c,
      output target_angle_a, target_angle_b, target_angle_c,
      input  ready
   );
   modport sink (
      input  valid, measured_angle_a, measured_angle_b, measured_angle_c,
      input  target_angle_a, target_angle_b, target_angle_c,
      output ready
   );
endinterface

// ===== rtl/core/jpid_rsp_if.sv =====
`timescale 1ns / 1ps

interface jpid_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] torque_a;
   logic signed [15:0] torque_b;
   logic signed [15:0] torque_c;

   modport source (output valid, torque_a, torque_b, torque_c, input ready);
   modport sink (input valid, torque_a, torque_b, torque_c, output ready);
endinterface

// ===== rtl/core/jpid_ctrl.sv =====
`timescale 1ns / 1ps

module jpid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  out_take,
   output logic                  out_push,
   output jpid_pkg::jpid_ctl_type ctl
);
   import jpid_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   en;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      en[STAGES] = out_take;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = en[0];
   assign out_push = valid_ff[STAGES-1];
   assign ctl.load = en[STAGES-1:0];
   assign ctl.take = {en[1] && valid_ff[0], en[0] && in_valid};

   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted beat did not reach the first stage");

   a_last_holds : assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && !out_take |=> valid_ff[STAGES-1])
      else $error("stalled last stage lost its beat");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (&valid_ff) && !out_take)
      else $error("input stalled with room in the pipeline");

endmodule

// ===== rtl/core/jpid_lane.sv =====
`timescale 1ns / 1ps

module jpid_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  jpid_pkg::jpid_ctl_type                 ctl,
   input  jpid_pkg::jpid_cfg_type                 cfg,
   input  logic signed [jpid_pkg::ANGLE_W-1:0]    meas,
   input  logic signed [jpid_pkg::ANGLE_W-1:0]    targ,
   output logic        [jpid_pkg::QUOT_W-1:0]     quot
);
   import jpid_pkg::*;

   localparam int PROD3_W   = SUM_W - 1 + RECIP3_W;
   localparam int PROD125_W = SPAN_W + RECIP125_W;
   localparam logic signed [SCALED_W-1:0] SPAN_HI = SCALED_W'(TQ_SPAN);
   localparam logic signed [SCALED_W-1:0] SPAN_LO = -SPAN_HI;

   // stage 1: difference, error, window check
   logic signed [ANGLE_W-1:0] last_angle_ff;
   logic signed [ERR_W-1:0]   diff;
   logic signed [ERR_W-1:0]   err_in;
   logic        [ERR_W-1:0]   err_mag;
   logic signed [VEL_W-1:0]   raw_in;
   logic                      outside_in;
   logic signed [VEL_W-1:0]   raw1_ff;
   logic signed [ERR_W-1:0]   err1_ff;
   logic                      outside1_ff;

   assign diff       = ERR_W'(meas) - ERR_W'(last_angle_ff);
   assign err_in     = ERR_W'(targ) - ERR_W'(meas);
   assign raw_in     = VEL_W'(diff) * VEL_W'(TICKS_PER_SEC);
   assign err_mag    = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
   assign outside_in = err_mag >= ERR_W'(cfg.window);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
      end else if (ctl.take[0]) begin
         last_angle_ff <= meas;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         raw1_ff     <= raw_in;
         err1_ff     <= err_in;
         outside1_ff <= outside_in;
      end
   end

   // stage 2: velocity filter and integrator, both closing within this stage
   logic signed [VEL_W-1:0]   hist_one_ff;
   logic signed [VEL_W-1:0]   hist_two_ff;
   logic signed [SUM_W-1:0]   vel_sum;
   logic        [SUM_W-2:0]   sum_mag;
   logic        [PROD3_W-1:0] prod3;
   logic        [VEL_W-2:0]   quot3;
   logic signed [VEL_W-1:0]   filt_in;
   logic signed [ERR_W-1:0]   last_error_ff;
   logic signed [INT_W-1:0]   integral_ff;
   logic signed [INT_W+1:0]   integ_sum;
   logic signed [INT_W-1:0]   integ_sat;
   logic signed [INT_W-1:0]   integ_in;
   logic signed [ERR_W-1:0]   err2_ff;
   logic signed [VEL_W-1:0]   filt2_ff;
   logic signed [INT_W-1:0]   integ2_ff;

   assign vel_sum = SUM_W'(raw1_ff) + SUM_W'(hist_one_ff) + SUM_W'(hist_two_ff);
   assign sum_mag = vel_sum[SUM_W-1] ? (SUM_W-1)'(-vel_sum) : (SUM_W-1)'(vel_sum);
   assign prod3   = PROD3_W'(sum_mag) * PROD3_W'(RECIP3);
   assign quot3   = prod3[RECIP3_SH +: VEL_W-1];
   // truncate toward zero: divide the magnitude, restore the sign
   assign filt_in = vel_sum[SUM_W-1] ? -$signed({1'b0, quot3}) : $signed({1'b0, quot3});

   assign integ_sum = (INT_W+2)'(integral_ff) + (INT_W+2)'(last_error_ff)
                    + (INT_W+2)'(err1_ff);

   always_comb begin
      if ((&integ_sum[INT_W+1:INT_W-1]) || !(|integ_sum[INT_W+1:INT_W-1])) begin
         integ_sat = integ_sum[INT_W-1:0];
      end else if (integ_sum[INT_W+1]) begin
         integ_sat = {1'b1, {(INT_W-1){1'b0}}};
      end else begin
         integ_sat = {1'b0, {(INT_W-1){1'b1}}};
      end
   end

   // drop the integral once the error leaves the window
   assign integ_in = outside1_ff ? '0 : integ_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_one_ff   <= '0;
         hist_two_ff   <= '0;
         last_error_ff <= '0;
         integral_ff   <= '0;
      end else if (ctl.take[1]) begin
         hist_two_ff   <= hist_one_ff;
         hist_one_ff   <= filt_in;
         last_error_ff <= err1_ff;
         integral_ff   <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         err2_ff   <= err1_ff;
         filt2_ff  <= filt_in;
         integ2_ff <= integ_in;
      end
   end

   // stage 3: gain products
   logic signed [P_W-1:0] p3_ff;
   logic signed [D_W-1:0] d3_ff;
   logic signed [I_W-1:0] i3_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         p3_ff <= $signed({1'b0, cfg.gain_p}) * err2_ff;
         d3_ff <= $signed({1'b0, cfg.gain_d}) * filt2_ff;
         i3_ff <= $signed({1'b0, cfg.gain_i}) * integ2_ff;
      end
   end

   // stage 4: proportional minus derivative
   logic signed [PD_W-1:0] pd4_ff;
   logic signed [I_W-1:0]  i4_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         pd4_ff <= PD_W'(p3_ff) - PD_W'(d3_ff);
         i4_ff  <= i3_ff;
      end
   end

   // stage 5: scale P minus D by 2000, add I, floor by 2^12, clamp, bias to non-negative
   logic signed [NUM_W-1:0]    pd_ext;
   logic signed [NUM_W-1:0]    num;
   logic signed [SCALED_W-1:0] scaled;
   logic signed [SCALED_W-1:0] clamped;
   logic signed [SCALED_W-1:0] biased;
   logic        [SPAN_W-1:0]   span5_ff;

   assign pd_ext = NUM_W'(pd4_ff);
   // 2000 = 2048 - 32 - 16
   assign num    = (pd_ext <<< 11) - (pd_ext <<< 5) - (pd_ext <<< 4) + NUM_W'(i4_ff);
   assign scaled = num[NUM_W-1:TQ_SH];

   always_comb begin
      if (scaled > SPAN_HI) begin
         clamped = SPAN_HI;
      end else if (scaled < SPAN_LO) begin
         clamped = SPAN_LO;
      end else begin
         clamped = scaled;
      end
   end

   assign biased = clamped + SPAN_HI;

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         span5_ff <= biased[SPAN_W-1:0];
      end
   end

   // stage 6: divide by the odd part of the torque divisor
   logic [PROD125_W-1:0] prod125;
   logic [QUOT_W-1:0]    quot6_ff;

   assign prod125 = PROD125_W'(span5_ff) * PROD125_W'(RECIP125);

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         quot6_ff <= prod125[RECIP125_SH +: QUOT_W];
      end
   end

   assign quot = quot6_ff;

endmodule

// ===== rtl/core/jpid_merge.sv =====
`timescale 1ns / 1ps

module jpid_merge (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             push,
   output logic                                             take,
   input  logic [jpid_pkg::JOINTS-1:0][jpid_pkg::QUOT_W-1:0] quot,
   input  logic [jpid_pkg::LIMIT_W-1:0]                     limit,
   jpid_rsp_if.source                                       rsp
);
   import jpid_pkg::*;

   localparam int Q_W = QUOT_W + 1;
   localparam logic signed [Q_W-1:0] BIAS = Q_W'(TQ_BIAS);

   logic                                   valid_ff;
   logic [JOINTS-1:0][TORQUE_W-1:0]        torque_ff;
   logic [JOINTS-1:0][TORQUE_W-1:0]        torque_in;
   logic signed [Q_W-1:0]                  lim_hi;
   logic signed [Q_W-1:0]                  lim_lo;

   assign lim_hi = $signed(Q_W'(limit));
   assign lim_lo = -lim_hi;

   // remove the bias and saturate each lane to the torque limit
   always_comb begin
      logic signed [Q_W-1:0] q;
      for (int j = 0; j < JOINTS; j++) begin
         q = $signed({1'b0, quot[j]}) - BIAS;
         if (q > lim_hi) begin
            torque_in[j] = lim_hi[TORQUE_W-1:0];
         end else if (q < lim_lo) begin
            torque_in[j] = lim_lo[TORQUE_W-1:0];
         end else begin
            torque_in[j] = q[TORQUE_W-1:0];
         end
      end
   end

   assign take = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (take && push) begin
         torque_ff <= torque_in;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.torque_a = torque_ff[0];
   assign rsp.torque_b = torque_ff[1];
   assign rsp.torque_c = torque_ff[2];

endmodule

// ===== rtl/core/joint_pid_with_velocity_filter.sv =====
`timescale 1ns / 1ps

// Three-joint PID position controller with a velocity estimate averaged over
// the new raw velocity and the two previous estimates, and an integrator that
// is cleared whenever the error leaves the integration window. One request
// beat carries measured and target angles for all joints (signed Q3.12); one
// response beat returns the saturated torques. A new beat is taken every cycle
// while the response side does not stall; each response passes the six lane
// stages and then the output register before it turns valid. The one-beat
// rate is held by the per-joint velocity filter and integrator, whose state
// closes within one stage; the depth comes from the gain products and the
// two reciprocal multiplies of each lane. Gains, window and limit are written
// through the APB port at byte addresses 0, 4, 8, 12 and 16; the user must write
// them only while no beat is in flight, and the block does not enforce this.
module joint_pid_with_velocity_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   jpid_req_if.sink                             req_ch,
   jpid_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [jpid_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [jpid_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [jpid_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import jpid_pkg::*;

   jpid_cfg_type                      cfg_ff;
   jpid_reg_type                      reg_sel;
   logic                              csr_write;
   jpid_ctl_type                      ctl;
   logic                              out_take;
   logic                              out_push;
   logic [JOINTS-1:0][ANGLE_W-1:0]    meas;
   logic [JOINTS-1:0][ANGLE_W-1:0]    targ;
   logic [JOINTS-1:0][QUOT_W-1:0]     quot;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = jpid_reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p <= RST_GAIN_P;
         cfg_ff.gain_d <= RST_GAIN_D;
         cfg_ff.gain_i <= RST_GAIN_I;
         cfg_ff.window <= RST_WINDOW;
         cfg_ff.limit  <= RST_LIMIT;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_GAIN_P: cfg_ff.gain_p <= csr_pwdata[GAIN_W-1:0];
            REG_GAIN_D: cfg_ff.gain_d <= csr_pwdata[GAIN_W-1:0];
            REG_GAIN_I: cfg_ff.gain_i <= csr_pwdata[GAIN_W-1:0];
            REG_WINDOW: cfg_ff.window <= csr_pwdata[WINDOW_W-1:0];
            REG_LIMIT:  cfg_ff.limit  <= csr_pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_GAIN_P: csr_prdata = CSR_DATA_W'(cfg_ff.gain_p);
         REG_GAIN_D: csr_prdata = CSR_DATA_W'(cfg_ff.gain_d);
         REG_GAIN_I: csr_prdata = CSR_DATA_W'(cfg_ff.gain_i);
         REG_WINDOW: csr_prdata = CSR_DATA_W'(cfg_ff.window);
         REG_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.limit);
         default:    csr_prdata = '0;
      endcase
   end

   assign meas[0] = req_ch.measured_angle_a;
   assign meas[1] = req_ch.measured_angle_b;
   assign meas[2] = req_ch.measured_angle_c;
   assign targ[0] = req_ch.target_angle_a;
   assign targ[1] = req_ch.target_angle_b;
   assign targ[2] = req_ch.target_angle_c;

   jpid_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .out_take (out_take),
      .out_push (out_push),
      .ctl      (ctl)
   );

   for (genvar j = 0; j < JOINTS; j++) begin : g_lane
      jpid_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .cfg   (cfg_ff),
         .meas  (meas[j]),
         .targ  (targ[j]),
         .quot  (quot[j])
      );
   end

   jpid_merge u_merge (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .take  (out_take),
      .quot  (quot),
      .limit (cfg_ff.limit),
      .rsp   (rsp_ch)
   );

endmodule
